@@ rtl/rsi_pkg.sv @@
// Shared types, constants and helpers of the ray/sphere intersection block.
`default_nettype none

package rsi_pkg;

    // Width of one limb of the wide multipliers.
    localparam int LIMB_W = 32;
    // Width of the radius register and its value after reset (1.0 in Q16.16).
    localparam int RADIUS_W = 31;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
    // Default depth of the queue between the front and back parts.
    localparam int FIFO_DEPTH_DEF = 4;
    // Root width of both lanes of the square root pipeline; radicands are twice as wide.
    localparam int SQRT_W = 96;
    // Magnitude of the chosen root, |H +/- S|.
    localparam int MAG_W = 66;
    // Fraction bits of the Q16.16 format.
    localparam int FRAC_W = 16;
    // Width of |v| * mag and of the numerator (|v| * mag shifted by the fraction).
    localparam int PROD_W = 98;
    localparam int NUM_W = PROD_W + FRAC_W;
    // Quotient bits produced by the divider; anything larger saturates.
    localparam int QUO_W = 32;
    // Saturation limits of a point magnitude.
    localparam logic [QUO_W-1:0] POS_LIM = 32'h7fff_ffff;
    localparam logic [QUO_W-1:0] NEG_LIM = 32'h8000_0000;

    // One classified ray as handed from the front part to the back part.
    typedef struct packed {
        logic [2:0][LIMB_W-1:0] vm;     // direction magnitudes
        logic [2:0]             vs;     // direction signs
        logic [63:0]            a;      // v.v
        logic [63:0]            hmag;   // |v.u|
        logic                   hneg;   // v.u < 0
        logic [63:0]            cmag;   // |u.u - r^2|
        logic                   cpos;   // u.u - r^2 > 0
        logic                   miss;   // miss already known
    } work_t;

    // Magnitude of a two's complement word.
    function automatic logic [LIMB_W-1:0] abs32(input logic [LIMB_W-1:0] x);
        return x[LIMB_W-1] ? (LIMB_W'(0) - x) : x;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rsi_if.sv @@
// Handshake interfaces of the ray/sphere intersection block.
`default_nettype none

// Ray word: direction and origin relative to the sphere center.
interface rsi_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;

    modport source (output valid, ray_dir_x, ray_dir_y, ray_dir_z,
                    origin_x, origin_y, origin_z, input ready);
    modport sink (input valid, ray_dir_x, ray_dir_y, ray_dir_z,
                  origin_x, origin_y, origin_z, output ready);
endinterface

// Result word: hit flag and hit point.
interface rsi_hit_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, hit, point_x, point_y, point_z, input ready);
    modport sink (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

// Configuration word: sphere radius.
interface rsi_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] sphere_radius;

    modport source (output valid, sphere_radius, input ready);
    modport sink (input valid, sphere_radius, output ready);
endinterface

`default_nettype wire

@@ rtl/rsi_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, several lanes in lockstep.
`default_nettype none

module rsi_isqrt #(
    parameter int RES_W = 96,
    parameter int LANES = 2,
    parameter int SB_W  = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [LANES-1:0][2*RES_W-1:0]   rad,
    input  logic [SB_W-1:0]                 sb_in,
    output logic                            out_vld,
    output logic [LANES-1:0][RES_W-1:0]     root,
    output logic [SB_W-1:0]                 sb_out
);

    localparam int REM_W = RES_W + 2;

    logic [RES_W-1:0]                  vld_reg;
    logic [LANES-1:0][2*RES_W-1:0]     x_reg    [RES_W];
    logic [LANES-1:0][REM_W-1:0]       rem_reg  [RES_W];
    logic [LANES-1:0][RES_W-1:0]       root_reg [RES_W];
    logic [SB_W-1:0]                   sb_reg   [RES_W];

    for (genvar k = 0; k < RES_W; k++) begin : g_stage
        logic                          vld_cur;
        logic [LANES-1:0][2*RES_W-1:0] x_cur;
        logic [LANES-1:0][REM_W-1:0]   rem_cur;
        logic [LANES-1:0][RES_W-1:0]   root_cur;
        logic [SB_W-1:0]               sb_cur;
        logic [LANES-1:0][2*RES_W-1:0] x_next;
        logic [LANES-1:0][REM_W-1:0]   rem_next;
        logic [LANES-1:0][RES_W-1:0]   root_next;

        // The first stage starts from the radicand with an empty remainder.
        if (k == 0) begin : g_first
            assign vld_cur  = in_vld;
            assign x_cur    = rad;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign sb_cur   = sb_in;
        end else begin : g_later
            assign vld_cur  = vld_reg[k-1];
            assign x_cur    = x_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign sb_cur   = sb_reg[k-1];
        end

        // Bring down two radicand bits and try to set the next root bit.
        always_comb
        begin
            logic [REM_W-1:0] rs;
            logic [REM_W-1:0] trial;
            logic             ge;
            for (int l = 0; l < LANES; l++)
            begin
                rs           = {rem_cur[l][RES_W-1:0], x_cur[l][2*RES_W-1 -: 2]};
                trial        = {root_cur[l], 2'b01};
                ge           = (rs >= trial);
                rem_next[l]  = ge ? (rs - trial) : rs;
                root_next[l] = {root_cur[l][RES_W-2:0], ge};
                x_next[l]    = {x_cur[l][2*RES_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sb_reg[k]   <= sb_cur;
            end
        end
    end

    assign out_vld = vld_reg[RES_W-1];
    assign root    = root_reg[RES_W-1];
    assign sb_out  = sb_reg[RES_W-1];

endmodule

`default_nettype wire

@@ rtl/rsi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
`default_nettype none

module rsi_div #(
    parameter int QUO_W = 32,
    parameter int DEN_W = 96,
    parameter int LANES = 3,
    parameter int SB_W  = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [LANES-1:0][DEN_W-1:0]   rem_in,
    input  logic [LANES-1:0][QUO_W-1:0]   low_in,
    input  logic [DEN_W-1:0]              den,
    input  logic [SB_W-1:0]               sb_in,
    output logic                          out_vld,
    output logic [LANES-1:0][QUO_W-1:0]   quo,
    output logic [SB_W-1:0]               sb_out
);

    logic [QUO_W-1:0]                vld_reg;
    logic [LANES-1:0][DEN_W-1:0]     rem_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]     low_reg [QUO_W];
    logic [DEN_W-1:0]                den_reg [QUO_W];
    logic [SB_W-1:0]                 sb_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                        vld_cur;
        logic [LANES-1:0][DEN_W-1:0] rem_cur;
        logic [LANES-1:0][QUO_W-1:0] low_cur;
        logic [DEN_W-1:0]            den_cur;
        logic [SB_W-1:0]             sb_cur;
        logic [LANES-1:0][DEN_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0] low_next;

        if (k == 0) begin : g_first
            assign vld_cur = in_vld;
            assign rem_cur = rem_in;
            assign low_cur = low_in;
            assign den_cur = den;
            assign sb_cur  = sb_in;
        end else begin : g_later
            assign vld_cur = vld_reg[k-1];
            assign rem_cur = rem_reg[k-1];
            assign low_cur = low_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign sb_cur  = sb_reg[k-1];
        end

        // Shift in the next dividend bit; the quotient bit fills the freed slot.
        always_comb
        begin
            logic [DEN_W:0] rs;
            logic [DEN_W:0] diff;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                rs          = {rem_cur[l], low_cur[l][QUO_W-1]};
                ge          = (rs >= {1'b0, den_cur});
                diff        = rs - {1'b0, den_cur};
                rem_next[l] = ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
                low_next[l] = {low_cur[l][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_next;
                den_reg[k] <= den_cur;
                sb_reg[k]  <= sb_cur;
            end
        end
    end

    assign out_vld = vld_reg[QUO_W-1];
    assign quo     = low_reg[QUO_W-1];
    assign sb_out  = sb_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ rtl/rsi_fifo.sv @@
// Short queue of classified rays between the front and back parts.
`default_nettype none

module rsi_fifo #(
    parameter int DEPTH = rsi_pkg::FIFO_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rsi_pkg::work_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output rsi_pkg::work_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsi_pkg::work_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage of the queued words.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ rtl/rsi_front.sv @@
// Front part: accepts rays, forms the dot products and classifies early misses.
`default_nettype none

module rsi_front (
    input  logic                            clk,
    input  logic                            rst_n,
    rsi_ray_if.sink                         ray,
    input  logic [rsi_pkg::RADIUS_W-1:0]    radius,
    input  logic                            q_full,
    output logic                            push,
    output rsi_pkg::work_t                  item
);

    localparam int LW = rsi_pkg::LIMB_W;
    localparam int RR_W = 2 * rsi_pkg::RADIUS_W;

    logic                         adv;
    logic [3:0]                   vld_reg;
    logic [2:0][LW-1:0]           dir_in, org_in;

    // Stage 0: magnitudes and signs.
    logic [2:0][LW-1:0]           vm0_reg, um0_reg;
    logic [2:0]                   vs0_reg, us0_reg;
    logic [rsi_pkg::RADIUS_W-1:0] r0_reg;
    // Stage 1: products.
    logic [2:0][63:0]             vv1_reg, uu1_reg, vu1_reg;
    logic [2:0][63:0]             vv1_next, uu1_next, vu1_next;
    logic [2:0]                   xs1_reg, vs1_reg;
    logic [2:0][LW-1:0]           vm1_reg;
    logic [RR_W-1:0]              rr1_reg, rr1_next;
    // Stage 2: sums.
    logic [63:0]                  a2_reg, su2_reg, hp2_reg, hn2_reg;
    logic [63:0]                  a2_next, su2_next, hp2_next, hn2_next;
    logic [RR_W-1:0]              rr2_reg;
    logic [2:0]                   vs2_reg;
    logic [2:0][LW-1:0]           vm2_reg;
    // Stage 3: classified word.
    rsi_pkg::work_t               item_reg, item_next;

    assign dir_in = {ray.ray_dir_z, ray.ray_dir_y, ray.ray_dir_x};
    assign org_in = {ray.origin_z, ray.origin_y, ray.origin_x};

    // The front moves whenever its last word can leave into the queue.
    assign adv       = !vld_reg[3] || !q_full;
    assign ray.ready = adv;
    assign push      = vld_reg[3] && adv;
    assign item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], ray.valid};
        end
    end

    // Per-component products and their sums.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vv1_next[i] = 64'(vm0_reg[i]) * 64'(vm0_reg[i]);
            uu1_next[i] = 64'(um0_reg[i]) * 64'(um0_reg[i]);
            vu1_next[i] = 64'(vm0_reg[i]) * 64'(um0_reg[i]);
        end
        rr1_next = RR_W'(r0_reg) * RR_W'(r0_reg);

        a2_next  = '0;
        su2_next = '0;
        hp2_next = '0;
        hn2_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            a2_next  = a2_next + vv1_reg[i];
            su2_next = su2_next + uu1_reg[i];
            if (xs1_reg[i])
            begin
                hn2_next = hn2_next + vu1_reg[i];
            end
            else
            begin
                hp2_next = hp2_next + vu1_reg[i];
            end
        end
    end

    // Signs of v.u and of u.u - r^2, and the misses known this early.
    always_comb
    begin
        item_next.vm   = vm2_reg;
        item_next.vs   = vs2_reg;
        item_next.a    = a2_reg;
        item_next.hneg = (hn2_reg > hp2_reg);
        item_next.hmag = item_next.hneg ? (hn2_reg - hp2_reg) : (hp2_reg - hn2_reg);
        item_next.cpos = (su2_reg > 64'(rr2_reg));
        item_next.cmag = item_next.cpos ? (su2_reg - 64'(rr2_reg))
                                        : (64'(rr2_reg) - su2_reg);
        item_next.miss = (a2_reg == '0)
                      || (!item_next.hneg && (hp2_reg != hn2_reg) && item_next.cpos);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vm0_reg[i] <= rsi_pkg::abs32(dir_in[i]);
                um0_reg[i] <= rsi_pkg::abs32(org_in[i]);
                vs0_reg[i] <= dir_in[i][LW-1];
                us0_reg[i] <= org_in[i][LW-1];
            end
            r0_reg   <= radius;

            vv1_reg  <= vv1_next;
            uu1_reg  <= uu1_next;
            vu1_reg  <= vu1_next;
            rr1_reg  <= rr1_next;
            xs1_reg  <= vs0_reg ^ us0_reg;
            vs1_reg  <= vs0_reg;
            vm1_reg  <= vm0_reg;

            a2_reg   <= a2_next;
            su2_reg  <= su2_next;
            hp2_reg  <= hp2_next;
            hn2_reg  <= hn2_next;
            rr2_reg  <= rr1_reg;
            vs2_reg  <= vs1_reg;
            vm2_reg  <= vm1_reg;

            item_reg <= item_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && q_full) |-> (!ray.ready && !push))
        else $error("front advanced into a full queue");
`endif

endmodule

`default_nettype wire

@@ rtl/rsi_back.sv @@
// Back part: discriminant, square roots, division and saturation of the hit point.
`default_nettype none

module rsi_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_vld,
    input  rsi_pkg::work_t item,
    output logic           take,
    rsi_hit_if.source      result
);

    localparam int LW     = rsi_pkg::LIMB_W;
    localparam int SW     = rsi_pkg::SQRT_W;
    localparam int MW     = rsi_pkg::MAG_W;
    localparam int NW     = rsi_pkg::NUM_W;
    localparam int PW     = rsi_pkg::PROD_W;
    localparam int FW     = rsi_pkg::FRAC_W;
    localparam int QW     = rsi_pkg::QUO_W;
    localparam int HI_W   = NW - QW;
    localparam int D_W    = 129;

    // Word carried through the square root pipeline.
    typedef struct packed {
        logic [2:0][LW-1:0] vm;
        logic [2:0]         vs;
        logic [63:0]        hmag;
        logic               hneg;
        logic               miss;
    } root_sb_t;

    // Word carried through the divider.
    typedef struct packed {
        logic [2:0] vs;
        logic       tneg;
        logic       miss;
        logic [2:0] sat;
    } div_sb_t;

    logic adv;
    logic [3:0] pre_vld_reg;
    logic [3:0] mid_vld_reg;
    logic       out_vld_reg;

    // P1: partial products of H^2, A*C and A^2.
    logic [1:0][1:0][63:0] hh1_reg, ac1_reg, aa1_reg;
    logic [1:0][1:0][63:0] hh1_next, ac1_next, aa1_next;
    rsi_pkg::work_t        it1_reg, it2_reg;
    // P2: full products.
    logic [127:0]          h2_reg, ac2_reg, aa2_reg;
    logic [127:0]          h2_next, ac2_next, aa2_next;
    // P3: discriminant and partial products of A^3.
    logic [D_W-1:0]        d3_reg, d3_next;
    logic [3:0][1:0][63:0] a3p3_reg, a3p3_next;
    root_sb_t              sb3_reg, sb3_next;
    // P4: A^3.
    logic [2*SW-1:0]       a3_4_reg, a3_4_next;
    logic [D_W-1:0]        d4_reg;
    root_sb_t              sb4_reg;
    // Square roots.
    logic [1:0][2*SW-1:0]  rad;
    logic [1:0][SW-1:0]    root;
    logic                  root_vld;
    root_sb_t              root_sb;
    // P5: magnitude of the chosen root.
    logic [MW-1:0]         mag5_reg, mag5_next;
    logic                  tneg5_reg, tneg5_next;
    logic [SW-1:0]         q5_reg, q6_reg, q7_reg;
    logic [2:0][LW-1:0]    vm5_reg;
    logic [2:0]            vs5_reg, vs6_reg, vs7_reg;
    logic                  miss5_reg, miss6_reg, miss7_reg;
    logic                  tneg6_reg, tneg7_reg;
    // P6: partial products of |v| * mag.
    logic [2:0][2:0][63:0] pp6_reg, pp6_next;
    // P7: numerators.
    logic [2:0][NW-1:0]    num7_reg, num7_next;
    // P8: divider entry.
    logic [2:0][SW-1:0]    rem8_reg, rem8_next;
    logic [2:0][QW-1:0]    low8_reg, low8_next;
    logic [SW-1:0]         den8_reg;
    div_sb_t               dsb8_reg, dsb8_next;
    // Divider output.
    logic [2:0][QW-1:0]    quo;
    logic                  div_vld;
    div_sb_t               div_sb;
    // Output register.
    logic                  hit_reg, hit_next;
    logic [2:0][QW-1:0]    pt_reg, pt_next;

    // The whole back part moves whenever the output register can be refilled.
    assign adv  = !out_vld_reg || result.ready;
    assign take = item_vld && adv;

    assign result.valid   = out_vld_reg;
    assign result.hit     = hit_reg;
    assign result.point_x = pt_reg[0];
    assign result.point_y = pt_reg[1];
    assign result.point_z = pt_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
            mid_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_vld_reg <= {pre_vld_reg[2:0], item_vld};
            mid_vld_reg <= {mid_vld_reg[2:0], root_vld};
            out_vld_reg <= div_vld;
        end
    end

    // 32 by 32 limb products, then their sums.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                hh1_next[i][j] = 64'(item.hmag[LW*i +: LW]) * 64'(item.hmag[LW*j +: LW]);
                ac1_next[i][j] = 64'(item.a[LW*i +: LW]) * 64'(item.cmag[LW*j +: LW]);
                aa1_next[i][j] = 64'(item.a[LW*i +: LW]) * 64'(item.a[LW*j +: LW]);
            end
        end

        h2_next  = '0;
        ac2_next = '0;
        aa2_next = '0;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                h2_next  = h2_next  + (128'(hh1_reg[i][j]) << (LW * (i + j)));
                ac2_next = ac2_next + (128'(ac1_reg[i][j]) << (LW * (i + j)));
                aa2_next = aa2_next + (128'(aa1_reg[i][j]) << (LW * (i + j)));
            end
        end
    end

    // Discriminant H^2 - A*C with its miss test; limb products of A^2 * A.
    always_comb
    begin
        sb3_next.vm   = it2_reg.vm;
        sb3_next.vs   = it2_reg.vs;
        sb3_next.hmag = it2_reg.hmag;
        sb3_next.hneg = it2_reg.hneg;
        sb3_next.miss = it2_reg.miss || (it2_reg.cpos && (h2_reg < ac2_reg));
        d3_next = it2_reg.cpos ? ({1'b0, h2_reg} - {1'b0, ac2_reg})
                               : ({1'b0, h2_reg} + {1'b0, ac2_reg});
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                a3p3_next[i][j] = 64'(aa2_reg[LW*i +: LW]) * 64'(it2_reg.a[LW*j +: LW]);
            end
        end

        a3_4_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                a3_4_next = a3_4_next + ((2*SW)'(a3p3_reg[i][j]) << (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hh1_reg  <= hh1_next;
            ac1_reg  <= ac1_next;
            aa1_reg  <= aa1_next;
            it1_reg  <= item;
            h2_reg   <= h2_next;
            ac2_reg  <= ac2_next;
            aa2_reg  <= aa2_next;
            it2_reg  <= it1_reg;
            d3_reg   <= d3_next;
            a3p3_reg <= a3p3_next;
            sb3_reg  <= sb3_next;
            a3_4_reg <= a3_4_next;
            d4_reg   <= d3_reg;
            sb4_reg  <= sb3_reg;
        end
    end

    // S = floor(sqrt(D)) in lane 0, Q = floor(sqrt(A^3)) in lane 1.
    assign rad[0] = (2*SW)'(d4_reg);
    assign rad[1] = a3_4_reg;

    rsi_isqrt #(
        .RES_W (SW),
        .LANES (2),
        .SB_W  ($bits(root_sb_t))
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (pre_vld_reg[3]),
        .rad     (rad),
        .sb_in   (sb4_reg),
        .out_vld (root_vld),
        .root    (root),
        .sb_out  (root_sb)
    );

    // Smaller root: -(H + S) scaled, sign kept apart from the magnitude.
    always_comb
    begin
        logic [MW-1:0] hb;
        logic [MW-1:0] sv;
        hb = MW'(root_sb.hmag);
        sv = root[0][MW-1:0];
        priority if (!root_sb.hneg)
        begin
            mag5_next  = hb + sv;
            tneg5_next = 1'b1;
        end
        else if (hb >= sv)
        begin
            mag5_next  = hb - sv;
            tneg5_next = 1'b0;
        end
        else
        begin
            mag5_next  = sv - hb;
            tneg5_next = 1'b1;
        end
    end

    // Numerators |v| * mag * 2^16 and the saturation check before dividing.
    always_comb
    begin
        logic [3*LW-1:0] mag_pad;
        logic [127:0]    prod;
        logic [HI_W-1:0] hi;
        mag_pad = (3*LW)'(mag5_reg);
        for (int l = 0; l < 3; l++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pp6_next[l][k] = 64'(vm5_reg[l]) * 64'(mag_pad[LW*k +: LW]);
            end
        end

        for (int l = 0; l < 3; l++)
        begin
            prod = '0;
            for (int k = 0; k < 3; k++)
            begin
                prod = prod + (128'(pp6_reg[l][k]) << (LW * k));
            end
            num7_next[l] = {prod[PW-1:0], {FW{1'b0}}};
        end

        dsb8_next.vs   = vs7_reg;
        dsb8_next.tneg = tneg7_reg;
        dsb8_next.miss = miss7_reg;
        for (int l = 0; l < 3; l++)
        begin
            hi                = num7_reg[l][NW-1:QW];
            dsb8_next.sat[l]  = (SW'(hi) >= q7_reg);
            rem8_next[l]      = SW'(hi);
            low8_next[l]      = num7_reg[l][QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag5_reg  <= mag5_next;
            tneg5_reg <= tneg5_next;
            q5_reg    <= root[1];
            vm5_reg   <= root_sb.vm;
            vs5_reg   <= root_sb.vs;
            miss5_reg <= root_sb.miss;

            pp6_reg   <= pp6_next;
            q6_reg    <= q5_reg;
            vs6_reg   <= vs5_reg;
            tneg6_reg <= tneg5_reg;
            miss6_reg <= miss5_reg;

            num7_reg  <= num7_next;
            q7_reg    <= q6_reg;
            vs7_reg   <= vs6_reg;
            tneg7_reg <= tneg6_reg;
            miss7_reg <= miss6_reg;

            rem8_reg  <= rem8_next;
            low8_reg  <= low8_next;
            den8_reg  <= q7_reg;
            dsb8_reg  <= dsb8_next;
        end
    end

    rsi_div #(
        .QUO_W (QW),
        .DEN_W (SW),
        .LANES (3),
        .SB_W  ($bits(div_sb_t))
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (mid_vld_reg[3]),
        .rem_in  (rem8_reg),
        .low_in  (low8_reg),
        .den     (den8_reg),
        .sb_in   (dsb8_reg),
        .out_vld (div_vld),
        .quo     (quo),
        .sb_out  (div_sb)
    );

    // Saturate, apply the sign, and force zeros on a miss.
    always_comb
    begin
        logic          neg;
        logic [QW-1:0] lim;
        logic [QW-1:0] qm;
        hit_next = !div_sb.miss;
        for (int l = 0; l < 3; l++)
        begin
            neg = div_sb.tneg ^ div_sb.vs[l];
            lim = neg ? rsi_pkg::NEG_LIM : rsi_pkg::POS_LIM;
            qm  = (div_sb.sat[l] || (quo[l] > lim)) ? lim : quo[l];
            if (div_sb.miss)
            begin
                pt_next[l] = '0;
            end
            else
            begin
                pt_next[l] = neg ? (QW'(0) - qm) : qm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            pt_reg  <= pt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.hit) |->
            (result.point_x == 0 && result.point_y == 0 && result.point_z == 0))
        else $error("miss word carries a nonzero point");
    a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(pre_vld_reg) && $stable(mid_vld_reg)))
        else $error("back pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/ray_sphere_intersect.sv @@
// Top level of the ray/sphere intersection block.
//
// Channels: ray (sink) takes one ray per word: direction and origin relative
// to the sphere center, signed Q16.16. result (source) gives one word per
// ray: the hit flag and the hit point t * v / |v| in Q16.16, saturated, and
// all zero on a miss. cfg (sink) writes the sphere radius and is always ready;
// the user must write it only with no ray in flight; the block does not enforce it.
// Throughput: one ray per cycle while the result side is ready.
// A ray's path to result valid runs through the front stages, the queue, and
// in the back part the 96-stage two-lane square root pipeline and the 32-stage divider.
// A queue of FIFO_DEPTH words lets the front keep taking rays while the back
// part is stalled; once the queue and the front stages fill, ray.ready drops.
// When the receiver stalls, the whole back pipeline holds its words.
// Reset empties every stage and the queue and sets the radius to 1.0.
`default_nettype none

module ray_sphere_intersect #(
    parameter int FIFO_DEPTH = rsi_pkg::FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rsi_ray_if.sink    ray,
    rsi_cfg_if.sink    cfg,
    rsi_hit_if.source  result
);

    logic [rsi_pkg::RADIUS_W-1:0] radius_reg, radius_next;
    logic                         q_full;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_not_empty;
    rsi_pkg::work_t               front_item;
    rsi_pkg::work_t               q_head;

    // Radius register.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        radius_next = (cfg.valid && cfg.ready) ? cfg.sphere_radius : radius_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= rsi_pkg::RADIUS_RESET;
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end

    rsi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray    (ray),
        .radius (radius_reg),
        .q_full (q_full),
        .push   (q_push),
        .item   (front_item)
    );

    rsi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rsi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (q_not_empty),
        .item     (q_head),
        .take     (q_pop),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ verif/ray_sphere_intersect_tb.sv @@
// Testbench of the ray/sphere intersection block: random and directed rays checked against a predictor.
`default_nettype none

module ray_sphere_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] dx, dy, dz, ox, oy, oz;
    } ray_word_t;

    typedef struct {
        logic        hit;
        logic [31:0] px, py, pz;
    } hit_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rsi_ray_if ray_ch();
    rsi_cfg_if cfg_ch();
    rsi_hit_if res_ch();

    ray_sphere_intersect u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray    (ray_ch.sink),
        .cfg    (cfg_ch.sink),
        .result (res_ch.source)
    );

    always #10 clk = ~clk;

    ray_word_t   pending_rays[$];
    hit_word_t   expected_hits[$];
    logic [30:0] radius = rsi_pkg::RADIUS_RESET;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          hold_cycles = 0;

    // Append one ray word to the end of the pending queue.
    function automatic void queue_ray(ray_word_t r);
        pending_rays.insert(pending_rays.size(), r);
    endfunction

    // Floor square root, bit by bit from the top.
    function automatic logic [255:0] int_sqrt(logic [255:0] x);
        logic [255:0] root, trial;
        root = 0;
        for (int i = 127; i >= 0; i--) begin
            trial = root | (256'd1 << i);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    // Exact point computation of one ray, using wide unsigned integers.
    function automatic hit_word_t intersect_ray(ray_word_t r, logic [30:0] rad);
        hit_word_t      o;
        logic [31:0]    vm[3], um[3], comp_v[3], comp_u[3];
        bit             vs[3], us[3];
        logic [255:0]   a, hp, hn, su, r2, hmag, cmag, h2, ac, d, s, mag, q, num, quo, lim;
        bit             hneg, cpos, tneg, neg;
        o = '{1'b0, 32'd0, 32'd0, 32'd0};
        comp_v = '{r.dx, r.dy, r.dz};
        comp_u = '{r.ox, r.oy, r.oz};
        a = 0; hp = 0; hn = 0; su = 0;
        for (int i = 0; i < 3; i++) begin
            vs[i] = comp_v[i][31];
            us[i] = comp_u[i][31];
            vm[i] = vs[i] ? -comp_v[i] : comp_v[i];
            um[i] = us[i] ? -comp_u[i] : comp_u[i];
            a  += 256'(vm[i]) * 256'(vm[i]);
            su += 256'(um[i]) * 256'(um[i]);
            if (vs[i] ^ us[i]) hn += 256'(vm[i]) * 256'(um[i]);
            else hp += 256'(vm[i]) * 256'(um[i]);
        end
        hneg = hn > hp;
        hmag = hneg ? hn - hp : hp - hn;
        r2 = 256'(rad) * 256'(rad);
        cpos = su > r2;
        cmag = cpos ? su - r2 : r2 - su;
        if (a == 0) return o;
        if (!hneg && hmag != 0 && cpos) return o;
        h2 = hmag * hmag;
        ac = a * cmag;
        if (cpos) begin
            if (h2 < ac) return o;
            d = h2 - ac;
        end else begin
            d = h2 + ac;
        end
        s = int_sqrt(d);
        if (!hneg) begin
            mag = hmag + s;
            tneg = 1'b1;
        end else if (hmag >= s) begin
            mag = hmag - s;
            tneg = 1'b0;
        end else begin
            mag = s - hmag;
            tneg = 1'b1;
        end
        q = int_sqrt(a * a * a);
        for (int i = 0; i < 3; i++) begin
            neg = tneg ^ vs[i];
            num = (256'(vm[i]) << 16) * mag;
            quo = num / q;
            lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
            if (quo > lim) quo = lim;
            if (neg) quo = -quo;
            if (i == 0) o.px = quo[31:0];
            else if (i == 1) o.py = quo[31:0];
            else o.pz = quo[31:0];
        end
        o.hit = 1'b1;
        return o;
    endfunction

    // Ray driver: offers the oldest pending word, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_ch.valid <= 1'b0;
            {ray_ch.ray_dir_x, ray_ch.ray_dir_y, ray_ch.ray_dir_z} <= '0;
            {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} <= '0;
        end
        else
        begin
            if (ray_ch.valid && ray_ch.ready)
            begin
                expected_hits.insert(expected_hits.size(),
                                     intersect_ray(pending_rays.pop_front(), radius));
            end
            if (!(ray_ch.valid && !ray_ch.ready))
            begin
                if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ray_ch.valid     <= 1'b1;
                    ray_ch.ray_dir_x <= pending_rays[0].dx;
                    ray_ch.ray_dir_y <= pending_rays[0].dy;
                    ray_ch.ray_dir_z <= pending_rays[0].dz;
                    ray_ch.origin_x  <= pending_rays[0].ox;
                    ray_ch.origin_y  <= pending_rays[0].oy;
                    ray_ch.origin_z  <= pending_rays[0].oz;
                end
                else
                begin
                    ray_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, counted in its own process.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Result monitor: accepts words and compares them field by field.
    always @(posedge clk or negedge rst_n)
    begin
        hit_word_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (res_ch.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, res_ch.hit);
                        fail_count++;
                    end
                    if (res_ch.point_x !== want.px)
                    begin
                        $error("point_x: expected %h, got %h", want.px, res_ch.point_x);
                        fail_count++;
                    end
                    if (res_ch.point_y !== want.py)
                    begin
                        $error("point_y: expected %h, got %h", want.py, res_ch.point_y);
                        fail_count++;
                    end
                    if (res_ch.point_z !== want.pz)
                    begin
                        $error("point_z: expected %h, got %h", want.pz, res_ch.point_z);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Radius writes happen only with the pipeline drained.
    task automatic write_radius(logic [30:0] value);
        @(posedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.sphere_radius <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        radius = value;
    endtask

    task automatic drain_pipeline();
        while (pending_rays.size() > 0 || expected_hits.size() > 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            3: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        endcase
    endfunction

    // A ray aimed roughly through the sphere, so that most of them hit.
    task automatic add_aimed_ray(logic [30:0] rad);
        ray_word_t  r;
        int         scale;
        scale = $urandom_range(1, 8);
        r.ox = 32'(-$signed(rand_coord()) % (int'(rad) * scale + 1));
        r.oy = 32'($signed($urandom_range(0, 2 * (rad >> 1))) - $signed(rad >> 1));
        r.oz = 32'($signed($urandom_range(0, 2 * (rad >> 1))) - $signed(rad >> 1));
        r.dx = $urandom_range(1) ? 32'(int'(scale) << 16) : rand_coord();
        r.dy = rand_coord() >>> $urandom_range(0, 8);
        r.dz = rand_coord() >>> $urandom_range(0, 8);
        if ($urandom_range(1)) r.ox = 32'(-(int'(scale) * int'(rad)));
        queue_ray(r);
    endtask

    task automatic add_random_ray();
        ray_word_t r;
        r = '{rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord()};
        queue_ray(r);
    endtask

    // Random phase with the given sender idle and receiver stall rates.
    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 70) add_aimed_ray(radius);
            else add_random_ray();
        end
        drain_pipeline();
    endtask

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MAXN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hffff_0000;

    // Stimulus sequence.
    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.sphere_radius = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rays at the reset radius of 1.0.
        queue_ray('{ONE, 32'd0, 32'd0, 32'hfffd_0000, 32'd0, 32'd0});
        queue_ray('{ONE, 32'd0, 32'd0, 32'h0003_0000, 32'd0, 32'd0});
        queue_ray('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        queue_ray('{ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        queue_ray('{ONE, 32'd0, 32'd0, MONE, 32'd0, 32'd0});
        queue_ray('{MONE, 32'd0, 32'd0, ONE, 32'd0, 32'd0});
        queue_ray('{ONE, 32'd0, 32'd0, MONE, ONE, 32'd0});
        queue_ray('{ONE, 32'd0, 32'd0, MONE, 32'h0002_0000, 32'd0});
        queue_ray('{MAXP, MAXP, MAXP, MAXN, MAXN, MAXN});
        queue_ray('{MAXN, MAXN, MAXN, MAXP, MAXP, MAXP});
        queue_ray('{MAXN, 32'd0, 32'd0, MAXP, 32'd0, 32'd0});
        queue_ray('{32'd1, 32'd0, 32'd0, MAXN, 32'd0, 32'd0});
        queue_ray('{32'hffff_ffff, 32'hffff_ffff, 32'd1, 32'd0, 32'd0, 32'd0});
        queue_ray('{32'd0, 32'd0, ONE, 32'd0, 32'd0, MAXN});
        queue_ray('{32'd0, MONE, 32'd0, 32'd0, 32'h0000_8000, 32'd0});
        drain_pipeline();

        write_radius(31'd0);
        queue_ray('{ONE, 32'd0, 32'd0, MONE, 32'd0, 32'd0});
        queue_ray('{ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        queue_ray('{ONE, ONE, 32'd0, MONE, ONE, 32'd0});
        drain_pipeline();

        write_radius(31'h7fff_ffff);
        queue_ray('{ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        queue_ray('{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        queue_ray('{MAXP, MAXP, MAXP, MAXN, 32'd0, 32'd0});
        run_phase(40, 0, 0);

        write_radius(31'h0001_0000);
        run_phase(60, 0, 0);

        // Long receiver hold-off while more rays keep coming than the block holds.
        hold_cycles = 400;
        run_phase(200, 0, 0);

        write_radius(31'h0004_8000);
        run_phase(60, 67, 0);

        write_radius(31'd1);
        run_phase(40, 0, 67);

        write_radius(31'h0200_0000);
        run_phase(40, 0, 67);

        write_radius(31'($urandom()));
        run_phase(40, 13, 13);

        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
